// ===== sv/bfa_pkg.sv =====
// Shared definitions for the bitmap frame allocator.
// Field widths, register indexes, status codes and the word search result type.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int DEF_MAX_FRAMES  = 4096;
  localparam int DEF_FRAME_BYTES = 4096;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int FC_W      = 13;
  localparam int ADDR_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CMD_W     = 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b1;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  localparam logic [FC_W-1:0] FC_RESET = 13'd4096;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_res_t;

endpackage

// ===== sv/bfa_if.sv =====
// Valid/ready channel interfaces for the frame allocator command and result.
// Depends on bfa_pkg for field widths.
`timescale 1ns / 1ps

interface bfa_in_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] frame_address;

  modport source (output valid, output command, output frame_address, input ready);
  modport sink   (input valid, input command, input frame_address, output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_address, output status, input ready);
  modport sink   (input valid, input granted_address, input status, output ready);
endinterface

// ===== sv/bfa_find_free.sv =====
// Lowest free bit search over one 64-bit bitmap word.
// Depends on bfa_pkg for the result struct.
`timescale 1ns / 1ps

module bfa_find_free import bfa_pkg::*; (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_BITS-1:0] mask_i,
  output find_res_t            res_o
);

  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_bit;

  always_comb begin
    free_bits     = ~word_i & mask_i;
    // isolate the lowest set bit, then encode the one-hot result
    low_bit       = free_bits & (~free_bits + {{(WORD_BITS-1){1'b0}}, 1'b1});
    res_o         = '0;
    res_o.found   = |free_bits;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_bit[j]) begin
        res_o.bit_idx = res_o.bit_idx | BIT_W'(j);
      end
    end
  end

endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// Bitmap first-fit page frame allocator, top level.
// Depends on bfa_pkg, bfa_if and bfa_find_free.
//
//   channel  | direction | payload                        | transfer when
//   in_ch    | sink      | command, frame_address         | valid && ready
//   out_ch   | source    | granted_address, status        | valid && ready
//   cfg_*    | write     | cfg_index selects, cfg_wdata   | cfg_we high
//
// Allocate: scans k bitmap words, k = 1 .. ceil(active frames / 64), reading one
//   bitmap word from the memory per cycle. Zero frames: ST_NOMEM, no read.
// Free: read word, clear bit and write back, load result; out of range: ST_RANGE.
// After reset a clearing pass writes every bitmap word, with in_ch.ready low;
//   configuration writes are taken meanwhile.
// A finished result sits in the output register until taken; the next command
//   is accepted meanwhile and its result waits until the register frees.
// FRAME_BYTES must be a power of two.
`timescale 1ns / 1ps

module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int MAX_FRAMES  = DEF_MAX_FRAMES,
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  bfa_in_if.sink               in_ch,
  bfa_out_if.source            out_ch
);

  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int ACT_W      = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W      = (ACT_W > FC_W) ? ACT_W : FC_W;
  localparam int SHIFT      = $clog2(FRAME_BYTES);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FREE  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [FC_W-1:0]      frame_count_r;
  logic [ADDR_W-1:0]    base_address_r;
  logic [WA_W-1:0]      clr_w_r, clr_w_nxt;
  logic [WA_W-1:0]      scan_w_r, scan_w_nxt;
  logic [WA_W-1:0]      last_w_r, last_w_nxt;
  logic [WORD_BITS-1:0] last_mask_r, last_mask_nxt;
  logic [WA_W-1:0]      fr_word_r, fr_word_nxt;
  logic [BIT_W-1:0]     fr_bit_r, fr_bit_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic                 out_load;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en;
  logic [WA_W-1:0]      rd_addr;
  logic                 mem_we;
  logic [WA_W-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic                 in_xfer;
  logic [CMP_W-1:0]     act_n;
  logic [CMP_W-1:0]     act_n_m1;
  logic [ADDR_W-1:0]    offset;
  logic [ADDR_W-1:0]    free_idx;
  logic                 free_ok;
  logic [WORD_BITS-1:0] word_mask;
  find_res_t            find_res;
  logic [ADDR_W-1:0]    grant_off;

  bfa_find_free u_find (
    .word_i (rd_data_r),
    .mask_i (word_mask),
    .res_o  (find_res)
  );

  // active frame count, limited to capacity
  always_comb begin
    if (CMP_W'(frame_count_r) > CMP_W'(MAX_FRAMES)) begin
      act_n = CMP_W'(MAX_FRAMES);
    end else begin
      act_n = CMP_W'(frame_count_r);
    end
    act_n_m1 = act_n - {{(CMP_W-1){1'b0}}, 1'b1};
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign offset    = in_ch.frame_address - base_address_r;
  assign free_idx  = offset >> SHIFT;
  assign free_ok   = (in_ch.frame_address >= base_address_r) &&
                     (free_idx < ADDR_W'(act_n));
  assign word_mask = (scan_w_r == last_w_r) ? last_mask_r : '1;
  assign grant_off = ADDR_W'({scan_w_r, find_res.bit_idx}) << SHIFT;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    clr_w_nxt      = clr_w_r;
    scan_w_nxt     = scan_w_r;
    last_w_nxt     = last_w_r;
    last_mask_nxt  = last_mask_r;
    fr_word_nxt    = fr_word_r;
    fr_bit_nxt     = fr_bit_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_w_r;
        clr_w_nxt = clr_w_r + {{(WA_W-1){1'b0}}, 1'b1};
        if (clr_w_r == WA_W'(WORD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          res_addr_nxt = ALL_ONES;
          if (in_ch.command == CMD_ALLOC) begin
            if (act_n == '0) begin
              res_status_nxt = ST_NOMEM;
              state_nxt      = S_RESP;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = '0;
              scan_w_nxt    = '0;
              last_w_nxt    = act_n_m1[WA_W+BIT_W-1:BIT_W];
              // a partial last word masks off frames at or above the count
              if (act_n[BIT_W-1:0] == '0) begin
                last_mask_nxt = '1;
              end else begin
                last_mask_nxt = ~({WORD_BITS{1'b1}} << act_n[BIT_W-1:0]);
              end
              state_nxt = S_SCAN;
            end
          end else begin
            if (free_ok) begin
              rd_en       = 1'b1;
              rd_addr     = free_idx[WA_W+BIT_W-1:BIT_W];
              fr_word_nxt = free_idx[WA_W+BIT_W-1:BIT_W];
              fr_bit_nxt  = free_idx[BIT_W-1:0];
              state_nxt   = S_FREE;
            end else begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_RESP;
            end
          end
        end
      end
      S_SCAN: begin
        if (find_res.found) begin
          mem_we         = 1'b1;
          mem_waddr      = scan_w_r;
          mem_wdata      = rd_data_r | ({{(WORD_BITS-1){1'b0}}, 1'b1} << find_res.bit_idx);
          res_addr_nxt   = base_address_r + grant_off;
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else if (scan_w_r == last_w_r) begin
          res_addr_nxt   = ALL_ONES;
          res_status_nxt = ST_NOMEM;
          state_nxt      = S_RESP;
        end else begin
          // advance to the next word; its data arrives next cycle
          scan_w_nxt = scan_w_r + {{(WA_W-1){1'b0}}, 1'b1};
          rd_en      = 1'b1;
          rd_addr    = scan_w_nxt;
        end
      end
      S_FREE: begin
        mem_we         = 1'b1;
        mem_waddr      = fr_word_r;
        mem_wdata      = rd_data_r & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << fr_bit_r);
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_w_r        <= '0;
      out_valid_r    <= 1'b0;
      frame_count_r  <= FC_RESET;
      base_address_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_w_r     <= clr_w_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_COUNT:  frame_count_r  <= cfg_wdata[FC_W-1:0];
          CFG_BASE_ADDRESS: base_address_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_w_r     <= scan_w_nxt;
    last_w_r     <= last_w_nxt;
    last_mask_r  <= last_mask_nxt;
    fr_word_r    <= fr_word_nxt;
    fr_bit_r     <= fr_bit_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  // bitmap memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.granted_address = out_addr_r;
  assign out_ch.status          = out_status_r;

endmodule

// ===== sv/bfa_checker.sv =====
// Port-level checks for the bitmap frame allocator, bound to the top level.
// Depends on bfa_pkg for status codes and widths.
`timescale 1ns / 1ps

module bfa_checker import bfa_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ADDR_W-1:0]   out_granted_address,
  input logic [STATUS_W-1:0] out_status
);

  // one command in flight: ready drops right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a command transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOMEM || out_status == ST_RANGE))
    else $error("undefined status code");

  a_nomem_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOMEM |-> out_granted_address == ALL_ONES)
    else $error("failed allocate did not return all ones");

  a_range_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RANGE |-> out_granted_address == ALL_ONES)
    else $error("rejected free did not return all ones");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_granted_address (out_ch.granted_address),
  .out_status          (out_ch.status)
);

// ===== sim/tb_bitmap_frame_allocator.sv =====
// Testbench for bitmap_frame_allocator: allocate/free commands against a bitmap predictor.
// Uses the package and channel interfaces from the RTL tree (bfa_pkg, bfa_if).
`timescale 1ns / 1ps

module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  localparam int FRAMES      = DEF_MAX_FRAMES;
  localparam int MAP_WORDS   = FRAMES / WORD_BITS;
  localparam int FRAME_SHIFT = $clog2(DEF_FRAME_BYTES);
  localparam int PHASE_ITEMS = 210;
  localparam int MAX_PRINTS  = 60;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] frame_address;
  } frame_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();

  bitmap_frame_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  frame_req_t pending_reqs[$];
  grant_t     expected_grants[$];
  frame_req_t drive_req;
  logic       in_taken = 1'b0;
  int         mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Predictor state: used-frame bitmap plus its own copy of the registers.
  logic [WORD_BITS-1:0] used_map [MAP_WORDS];
  logic [FC_W-1:0]      model_frame_count;
  logic [ADDR_W-1:0]    model_base;

  // Settings of the current stimulus phase, used by the request generator.
  logic [FC_W-1:0]   ph_frame_count;
  logic [ADDR_W-1:0] ph_base;
  int unsigned       ph_alloc_pct;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void predict_grant(input frame_req_t req);
    int unsigned       active;
    int unsigned       idx;
    int unsigned       i;
    logic              found;
    logic [ADDR_W-1:0] offset;
    grant_t            g;
    active = (model_frame_count > FRAMES) ? FRAMES : model_frame_count;
    g.granted_address = ALL_ONES;
    if (req.command == CMD_ALLOC) begin
      g.status = ST_NOMEM;
      found = 1'b0;
      for (i = 0; i < active && !found; i++) begin
        if (!used_map[i / WORD_BITS][i % WORD_BITS]) begin
          found = 1'b1;
          used_map[i / WORD_BITS][i % WORD_BITS] = 1'b1;
          offset = i;
          g.granted_address = model_base + (offset << FRAME_SHIFT);
          g.status = ST_OK;
        end
      end
    end else begin
      g.status = ST_RANGE;
      if (req.frame_address >= model_base) begin
        offset = req.frame_address - model_base;
        idx = offset >> FRAME_SHIFT;
        if (idx < active) begin
          used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
          g.status = ST_OK;
        end
      end
    end
    expected_grants.push_back(g);
  endfunction

  // Sample everything at the rising edge: register writes, command and result transfers.
  always @(posedge clk) begin
    grant_t exp_g;
    in_taken <= in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      for (int w = 0; w < MAP_WORDS; w++) used_map[w] = '0;
      model_frame_count = FC_RESET;
      model_base = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_COUNT:  model_frame_count = cfg_wdata[FC_W-1:0];
          CFG_BASE_ADDRESS: model_base = cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_grant('{command: in_ch.command, frame_address: in_ch.frame_address});
      if (out_ch.valid && out_ch.ready) begin
        if (expected_grants.size() == 0) begin
          flag_mismatch($sformatf("unexpected result addr=%h status=%0d",
                                  out_ch.granted_address, out_ch.status));
        end else begin
          exp_g = expected_grants.pop_front();
          if (out_ch.granted_address !== exp_g.granted_address)
            flag_mismatch($sformatf("granted_address %h, want %h",
                                    out_ch.granted_address, exp_g.granted_address));
          if (out_ch.status !== exp_g.status)
            flag_mismatch($sformatf("status %0d, want %0d", out_ch.status, exp_g.status));
        end
      end
    end
  end

  // Command driver and result back-pressure, both on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_reqs.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.command       <= drive_req.command;
        in_ch.frame_address <= drive_req.frame_address;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  function automatic void push_req(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
    pending_reqs.push_back('{command: cmd, frame_address: addr});
  endfunction

  // Mostly well-formed traffic: allocates and frees of frames inside the window,
  // the rest is out-of-range or random addresses.
  function automatic void push_random_req();
    int unsigned       roll;
    int unsigned       active;
    logic [ADDR_W-1:0] offset;
    roll = $urandom_range(99);
    active = (ph_frame_count > FRAMES) ? FRAMES : ph_frame_count;
    if (roll < ph_alloc_pct) begin
      push_req(CMD_ALLOC, $urandom);
    end else if (roll < 90) begin
      offset = (active == 0) ? 0 : $urandom_range(active - 1);
      push_req(CMD_FREE, ph_base + (offset << FRAME_SHIFT) + $urandom_range(DEF_FRAME_BYTES - 1));
    end else begin
      case ($urandom_range(3))
        0: push_req(CMD_FREE, $urandom);
        1: begin
          offset = active;
          push_req(CMD_FREE, ph_base + (offset << FRAME_SHIFT) + $urandom_range(DEF_FRAME_BYTES - 1));
        end
        2: push_req(CMD_FREE, ph_base - 1 - $urandom_range(DEF_FRAME_BYTES - 1));
        default: push_req(CMD_FREE, $urandom_range(1) ? ALL_ONES : '0);
      endcase
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued command has been sent and every result has come back.
  task automatic wait_drain();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_grants.size() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_window(input logic [FC_W-1:0] fc, input logic [ADDR_W-1:0] base);
    ph_frame_count = fc;
    ph_base = base;
    write_reg(CFG_FRAME_COUNT, {{(ADDR_W-FC_W){1'b0}}, fc});
    write_reg(CFG_BASE_ADDRESS, base);
  endtask

  initial begin
    int unsigned n;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_ALLOC;
    in_ch.frame_address = '0;
    out_ch.ready        = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: three frames just below the top of the address space, so the
    // third grant wraps to zero; exhaust, unaligned and double frees, below-base.
    set_window(13'd3, 32'hFFFF_E000);
    push_req(CMD_ALLOC, 32'h0);
    push_req(CMD_ALLOC, 32'hFFFF_FFFF);
    push_req(CMD_ALLOC, 32'h0);
    push_req(CMD_ALLOC, 32'h0);
    push_req(CMD_FREE, 32'hFFFF_F123);
    push_req(CMD_FREE, 32'hFFFF_F000);
    push_req(CMD_ALLOC, 32'h0);
    push_req(CMD_FREE, 32'h0000_0000);
    push_req(CMD_FREE, 32'hFFFF_FFFF);
    push_req(CMD_FREE, 32'hFFFF_DFFF);
    push_req(CMD_FREE, 32'hFFFF_E000);
    wait_drain();

    // Zero frames: allocation always fails, every free is out of range.
    set_window(13'd0, 32'h0);
    push_req(CMD_ALLOC, 32'h0);
    push_req(CMD_FREE, 32'h0);
    wait_drain();

    // Count above capacity is clamped to the bitmap size.
    set_window(13'h1FFF, 32'h0);
    push_req(CMD_FREE, 32'hFFFF_FFFF);
    push_req(CMD_FREE, 32'h00FF_F000);
    push_req(CMD_FREE, 32'h0100_0000);
    push_req(CMD_ALLOC, 32'h0);
    push_req(CMD_ALLOC, 32'h0);
    wait_drain();

    // Lowered count: bits above it stay set but are unreachable.
    set_window(13'd1, 32'h0);
    push_req(CMD_ALLOC, 32'h0);
    push_req(CMD_FREE, 32'h0000_1000);
    push_req(CMD_FREE, 32'h0000_0FFF);
    push_req(CMD_ALLOC, 32'h0);
    wait_drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      ph_alloc_pct = 55;
      case (phase)
        0: set_window(FC_RESET, 32'h0);
        1: set_window(13'h1FFF, 32'hFFFF_FFFF);
        2: set_window(FC_W'($urandom_range(1, 40)), $urandom & 32'hFFFF_F000);
        3: set_window(13'd0, $urandom);
        4: begin
          ph_alloc_pct = 75;
          set_window(FC_W'($urandom_range(100, 300)), $urandom);
        end
        5: begin
          n = $urandom_range(2, 64);
          set_window(FC_W'(n), 32'h0 - ((n / 2) << FRAME_SHIFT));
        end
        6: begin
          ph_alloc_pct = 80;
          set_window(FC_RESET, 32'h0);
        end
        default: set_window(FC_W'($urandom_range(1, 4096)), $urandom);
      endcase
      // Pause the sender halfway until the block has answered everything.
      for (int k = 0; k < PHASE_ITEMS / 2; k++) push_random_req();
      wait_drain();
      for (int k = 0; k < PHASE_ITEMS - PHASE_ITEMS / 2; k++) push_random_req();
      wait_drain();
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bfa_pkg.sv
sv/bfa_if.sv
sv/bfa_find_free.sv
sv/bitmap_frame_allocator.sv
sv/bfa_checker.sv
sim/tb_bitmap_frame_allocator.sv
